/* hw/rtl/dsc_pkg.sv */
// ----------------------------------------------------------------------------
// dsc_pkg
// shared widths, constants and the arctangent table of the stick converter
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int AXIS_W    = 16;
  localparam int RAD_W     = 15;
  localparam int ANGLE_W   = 16;
  localparam int GUARD     = 8;
  localparam int DP_W      = 27;
  localparam int MAG_W     = DP_W - 1;
  localparam int TURN_W    = 32;
  localparam int TBL_LEN   = 24;
  localparam int TBL_IDX_W = 5;

  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [TURN_W-1:0] GAIN_RECIP = 32'h9B74EDA8;
  localparam logic [RAD_W-1:0]  RAD_MAX    = 15'h7FFF;

  function automatic logic [TURN_W-1:0] atan_turn(input logic [TBL_IDX_W-1:0] idx);
    logic [TURN_W-1:0] v;
    unique case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/dsc_cordic.sv */
// ----------------------------------------------------------------------------
// dsc_cordic
// iterative vectoring cordic, one micro-rotation per cycle
// ----------------------------------------------------------------------------
module dsc_cordic
  import dsc_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [AXIS_W-1:0] x_in,
  input  logic signed [AXIS_W-1:0] y_in,
  output logic                     done,
  output logic signed [DP_W-1:0]   x_out,
  output logic [TURN_W-1:0]        z_out
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] LAST = STEP_W'(CORDIC_STEPS - 1);

  logic                   running;
  logic [STEP_W-1:0]      step;
  logic signed [DP_W-1:0] cx, cy;
  logic [TURN_W-1:0]      z;
  logic signed [DP_W-1:0] xs, ys, sx, sy;
  logic [TURN_W-1:0]      at;

  always_comb begin
    xs = DP_W'(x_in) <<< GUARD;
    ys = DP_W'(y_in) <<< GUARD;
    sx = cx >>> step;
    sy = cy >>> step;
    at = atan_turn(TBL_IDX_W'(step));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= running && !start && (step == LAST);
      if (start) begin
        running <= 1'b1;
        step    <= '0;
        if (x_in[AXIS_W-1]) begin
          cx <= -xs;
          cy <= -ys;
          z  <= 32'h80000000;
        end else begin
          cx <= xs;
          cy <= ys;
          z  <= '0;
        end
      end else if (running) begin
        if (cy > 0) begin
          cx <= cx + sy;
          cy <= cy - sx;
          z  <= z + at;
        end else begin
          cx <= cx - sy;
          cy <= cy + sx;
          z  <= z - at;
        end
        if (step == LAST) begin
          running <= 1'b0;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  assign x_out = cx;
  assign z_out = z;

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !running)
    else $error("cordic done while still rotating");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    running && step == LAST && !start |=> done)
    else $error("cordic missed done after last step");
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !running)
    else $error("cordic restarted while busy");

endmodule

/* hw/rtl/dsc_gain.sv */
// ----------------------------------------------------------------------------
// dsc_gain
// cordic gain correction: registered multiply, round half up, saturate
// ----------------------------------------------------------------------------
module dsc_gain
  import dsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   load,
  input  logic signed [DP_W-1:0] x,
  output logic [RAD_W-1:0]       radius
);

  localparam int PROD_W = MAG_W + TURN_W;
  localparam int SH     = TURN_W + GUARD;
  localparam int HI_W   = PROD_W - SH;

  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] rsum;
  logic [HI_W-1:0]   hi;

  assign mag = (x > 0) ? x[MAG_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= {{TURN_W{1'b0}}, mag} * {{MAG_W{1'b0}}, GAIN_RECIP};
    end
  end

  always_comb begin
    rsum   = prod + (PROD_W'(1) << (SH - 1));
    hi     = rsum[PROD_W-1:SH];
    radius = (hi > HI_W'(RAD_MAX)) ? RAD_MAX : hi[RAD_W-1:0];
  end

endmodule

/* hw/rtl/dual_stick_cartesian_to_polar.sv */
// ----------------------------------------------------------------------------
// dual_stick_cartesian_to_polar
// magnitude and binary angle of two analog sticks through one shared cordic
// ----------------------------------------------------------------------------
// the left stick and then the right stick pass in turn through start, cordic run and round,
//   a centered stick skips the cordic and gives a zero radius with its held angle
// one shared cordic: a new word is taken only in idle, after the last one reached the output
// a word can be taken while the previous result still waits at the output
// reset: sequencer idle, no result pending, held angles cleared to zero
module dual_stick_cartesian_to_polar
  import dsc_pkg::*;
#(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  logic signed [AXIS_W-1:0] left_x,
  input  logic signed [AXIS_W-1:0] left_y,
  input  logic signed [AXIS_W-1:0] right_x,
  input  logic signed [AXIS_W-1:0] right_y,
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic [RAD_W-1:0]         left_radius,
  output logic [ANGLE_W-1:0]       left_angle,
  output logic [RAD_W-1:0]         right_radius,
  output logic [ANGLE_W-1:0]       right_angle
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam int ANGLE_MASK_I = 65536 - (1 << (16 - ANGLE_BITS));
  localparam logic [ANGLE_W-1:0] ANGLE_MASK = ANGLE_W'(ANGLE_MASK_I);
  localparam logic [TURN_W-1:0]  ANGLE_HALF = TURN_W'(1) << (31 - ANGLE_BITS);

  logic [2:0]               state;
  logic                     sel;
  logic signed [AXIS_W-1:0] lx, ly, rx, ry;
  logic signed [AXIS_W-1:0] cur_x, cur_y;
  logic                     centered;
  logic [RAD_W-1:0]         res_radius [0:1];
  logic [ANGLE_W-1:0]       res_angle [0:1];
  logic [ANGLE_W-1:0]       held_angle [0:1];
  logic                     cstart, cdone;
  logic signed [DP_W-1:0]   cx;
  logic [TURN_W-1:0]        cz;
  logic [TURN_W-1:0]        asum;
  logic [ANGLE_W-1:0]       angle;
  logic [RAD_W-1:0]         gradius;
  logic                     out_free;

  always_comb begin
    cur_x    = sel ? rx : lx;
    cur_y    = sel ? ry : ly;
    centered = (cur_x == '0) && (cur_y == '0);
    cstart   = (state == S_START) && !centered;
    asum     = cz + ANGLE_HALF;
    angle    = asum[TURN_W-1:TURN_W-ANGLE_W] & ANGLE_MASK;
    out_free = !result_valid || result_ready;
  end

  assign item_ready = (state == S_IDLE);

  dsc_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cstart),
    .x_in  (cur_x),
    .y_in  (cur_y),
    .done  (cdone),
    .x_out (cx),
    .z_out (cz)
  );

  dsc_gain u_gain (
    .clk    (clk),
    .load   (cdone),
    .x      (cx),
    .radius (gradius)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sel           <= 1'b0;
      result_valid  <= 1'b0;
      held_angle[0] <= '0;
      held_angle[1] <= '0;
    end else begin
      if (result_valid && result_ready && (state != S_OUT)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            lx    <= left_x;
            ly    <= left_y;
            rx    <= right_x;
            ry    <= right_y;
            sel   <= 1'b0;
            state <= S_START;
          end
        end
        S_START: begin
          if (centered) begin
            res_radius[sel] <= '0;
            res_angle[sel]  <= held_angle[sel];
            sel             <= 1'b1;
            state           <= sel ? S_OUT : S_START;
          end else begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (cdone) begin
            held_angle[sel] <= angle;
            res_angle[sel]  <= angle;
            state           <= S_ROUND;
          end
        end
        S_ROUND: begin
          res_radius[sel] <= gradius;
          sel             <= 1'b1;
          state           <= sel ? S_OUT : S_START;
        end
        S_OUT: begin
          if (out_free) begin
            left_radius  <= res_radius[0];
            left_angle   <= res_angle[0];
            right_radius <= res_radius[1];
            right_angle  <= res_angle[1];
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_in_run: assert property (@(posedge clk) disable iff (rst) cdone |-> state == S_RUN)
    else $error("cordic finished outside run state");
  a_held_stable: assert property (@(posedge clk) disable iff (rst)
    !cdone |=> $stable(held_angle[0]) && $stable(held_angle[1]))
    else $error("held angle changed without a cordic result");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("new word taken while converting");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the dual stick cartesian to polar converter against a cordic predictor:
// directed extremes, centered sticks holding their angle, random words under
// input gaps and output stalls, and a long output hold-off that fills the block
// ----------------------------------------------------------------------------
module testbench;
  import dsc_pkg::*;

  localparam int    ANGLE_BITS   = 16;
  localparam int    CORDIC_STEPS = 16;
  localparam int    LATENCY      = 2 * CORDIC_STEPS + 8;
  localparam int    HOLD_CYCLES  = 300;
  localparam int    SHOW_MAX     = 10;
  localparam int    PHASE_WORDS  = 205;
  localparam longint LIMIT_NS    = 4_000_000;
  localparam logic [31:0] GAIN_INV = 32'h9B74EDA8;
  localparam logic [15:0] AXIS_ONE = 16'sd16384;

  localparam logic [31:0] ATAN_TBL [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [AXIS_W-1:0] lx;
    logic signed [AXIS_W-1:0] ly;
    logic signed [AXIS_W-1:0] rx;
    logic signed [AXIS_W-1:0] ry;
  } stick_word_t;

  typedef struct packed {
    logic [RAD_W-1:0]   lrad;
    logic [ANGLE_W-1:0] lang;
    logic [RAD_W-1:0]   rrad;
    logic [ANGLE_W-1:0] rang;
  } polar_word_t;

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     item_valid   = 1'b0;
  logic                     item_ready;
  logic signed [AXIS_W-1:0] left_x       = '0;
  logic signed [AXIS_W-1:0] left_y       = '0;
  logic signed [AXIS_W-1:0] right_x      = '0;
  logic signed [AXIS_W-1:0] right_y      = '0;
  logic                     result_valid;
  logic                     result_ready = 1'b0;
  logic [RAD_W-1:0]         left_radius;
  logic [ANGLE_W-1:0]       left_angle;
  logic [RAD_W-1:0]         right_radius;
  logic [ANGLE_W-1:0]       right_angle;

  polar_word_t      polar_q[$];
  logic [ANGLE_W-1:0] left_held  = '0;
  logic [ANGLE_W-1:0] right_held = '0;
  int               mismatches = 0;
  int               send_idle_pct = 0;
  int               stall_pct = 0;
  int               hold_reqs = 0;
  int               hold_seen = 0;
  int               hold_left = 0;

  dual_stick_cartesian_to_polar #(
    .ANGLE_BITS  (ANGLE_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .left_x      (left_x),
    .left_y      (left_y),
    .right_x     (right_x),
    .right_y     (right_y),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .left_radius (left_radius),
    .left_angle  (left_angle),
    .right_radius(right_radius),
    .right_angle (right_angle)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  function automatic void stick_polar(input logic signed [AXIS_W-1:0] x,
                                      input logic signed [AXIS_W-1:0] y,
                                      inout logic [ANGLE_W-1:0] held,
                                      output logic [RAD_W-1:0] rad,
                                      output logic [ANGLE_W-1:0] ang);
    longint          cx;
    longint          cy;
    longint          nx;
    logic [31:0]     z;
    longint unsigned mag;
    longint unsigned r;
    if (x == 0 && y == 0) begin
      rad = '0;
      ang = held;
      return;
    end
    cx = longint'(x) * 256;
    cy = longint'(y) * 256;
    z  = '0;
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      z  = 32'h80000000;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (cy > 0) begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        z  = z + ATAN_TBL[i];
      end else begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        z  = z - ATAN_TBL[i];
      end
      cx = nx;
    end
    mag = (cx > 0) ? longint'(cx) : 64'd0;
    r = (mag * 64'(GAIN_INV) + (64'd1 << 39)) >> 40;
    if (r > 64'd32767) r = 64'd32767;
    rad = r[RAD_W-1:0];
    z = z + (32'd1 << (31 - ANGLE_BITS));
    z = z >> (32 - ANGLE_BITS);
    z = z & ((32'd1 << ANGLE_BITS) - 32'd1);
    z = z << (16 - ANGLE_BITS);
    held = z[ANGLE_W-1:0];
    ang  = held;
  endfunction

  function automatic polar_word_t predict_polar(input stick_word_t w);
    polar_word_t p;
    stick_polar(w.lx, w.ly, left_held, p.lrad, p.lang);
    stick_polar(w.rx, w.ry, right_held, p.rrad, p.rang);
    return p;
  endfunction

  function automatic logic signed [AXIS_W-1:0] rand_axis();
    logic [AXIS_W-1:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = 16'($urandom);
      2: begin
        case ($urandom_range(5))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = AXIS_ONE;
          3: v = -AXIS_ONE;
          4: v = 16'h0001;
          default: v = 16'hFFFF;
        endcase
      end
      default: v = 16'($urandom_range(32768)) - AXIS_ONE;
    endcase
    return v;
  endfunction

  function automatic stick_word_t rand_word();
    stick_word_t w;
    w.lx = rand_axis();
    w.ly = rand_axis();
    w.rx = rand_axis();
    w.ry = rand_axis();
    if ($urandom_range(11) == 0) begin
      w.lx = '0;
      w.ly = '0;
    end
    if ($urandom_range(11) == 0) begin
      w.rx = '0;
      w.ry = '0;
    end
    return w;
  endfunction

  // call right after a rising edge; returns at the edge that takes the word
  task automatic send_word(input stick_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    left_x     <= w.lx;
    left_y     <= w.ly;
    right_x    <= w.rx;
    right_y    <= w.ry;
    do @(posedge clk); while (!item_ready);
    polar_q.push_back(predict_polar(w));
  endtask

  task automatic send_sticks(input int lx, input int ly, input int rx, input int ry);
    stick_word_t w;
    w.lx = 16'(lx);
    w.ly = 16'(ly);
    w.rx = 16'(rx);
    w.ry = 16'(ry);
    send_word(w);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (polar_q.size() != 0);
  endtask

  task automatic test_axis_extremes();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_sticks(0, 0, 0, 0);
    send_sticks(16384, 0, 0, 16384);
    send_sticks(-16384, 0, 0, -16384);
    send_sticks(16384, 16384, -16384, -16384);
    send_sticks(-16384, 16384, 16384, -16384);
    send_sticks(-1, 0, 1, 0);
    send_sticks(0, 1, 0, -1);
    send_sticks(-1, -1, -1, 1);
    send_sticks(32767, 32767, -32768, -32768);
    send_sticks(-32768, 32767, 32767, -32768);
    send_sticks(-32768, 0, 0, -32768);
    send_sticks(-16384, -1, -16384, 1);
    send_sticks(11585, -11585, -5, 16383);
    drain();
  endtask

  task automatic test_centered_hold();
    send_sticks(10000, 5000, 0, 0);
    send_sticks(0, 0, -300, -7000);
    send_sticks(0, 0, 0, 0);
    send_sticks(-16384, 1, 0, 0);
    send_sticks(0, 0, 1, -16384);
    send_sticks(0, 0, 0, 0);
    drain();
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int words);
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int n = 0; n < words; n++) begin
      send_word(rand_word());
      if ($urandom_range(39) == 0) drain();
    end
    drain();
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_reqs     = hold_reqs + 1;
    for (int n = 0; n < 16; n++) send_word(rand_word());
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen    <= hold_reqs;
      hold_left    <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    polar_word_t want;
    polar_word_t got;
    if (!rst && result_valid && result_ready) begin
      got.lrad = left_radius;
      got.lang = left_angle;
      got.rrad = right_radius;
      got.rang = right_angle;
      if (polar_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("unexpected word: r%0d a%0d r%0d a%0d",
                   got.lrad, got.lang, got.rrad, got.rang);
      end else begin
        want = polar_q.pop_front();
        if (got.lrad !== want.lrad || got.lang !== want.lang ||
            got.rrad !== want.rrad || got.rang !== want.rang) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("mismatch: expected r%0d a%0d r%0d a%0d, got r%0d a%0d r%0d a%0d",
                     want.lrad, want.lang, want.rrad, want.rang,
                     got.lrad, got.lang, got.rrad, got.rang);
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_axis_extremes();
    test_centered_hold();
    test_random_phase(0, 0, PHASE_WORDS);
    test_random_phase(51, 0, PHASE_WORDS);
    test_random_phase(0, 51, PHASE_WORDS);
    test_output_backpressure();
    test_random_phase(36, 36, PHASE_WORDS);
    repeat (3 * LATENCY) @(posedge clk);
    if (mismatches == 0 && polar_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* dual_stick_cartesian_to_polar.f */
hw/rtl/dsc_pkg.sv
hw/rtl/dsc_cordic.sv
hw/rtl/dsc_gain.sv
hw/rtl/dual_stick_cartesian_to_polar.sv
verif/testbench.sv
